// ===== design/rqsd_pkg.sv =====
// shared types and constants for the sorted radius query block
package rqsd_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam int POS_W   = 16;
	localparam int DIFF_W  = POS_W + 1;
	localparam int D2_W    = 2 * DIFF_W;
	localparam int RAD_W   = 15;
	localparam int LIMIT_W = 2 * RAD_W;
	localparam int KEY_W   = RAD_W;
	localparam int ROOT_W  = 32;
	localparam int STEP_W  = 4;
	localparam int ID_W    = 4;

	localparam logic [RAD_W-1:0]  RADIUS_RESET = 15'd72;
	localparam logic [STEP_W-1:0] ROOT_FIRST   = 4'd15;

	typedef struct packed {
		logic                    op;
		logic [ID_W-1:0]         target_slot;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [ID_W-1:0]         skip_target;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0] target_id;
		logic            found;
		logic            last;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load_we;
		logic start;
		logic diff;
		logic mulx;
		logic muly;
		logic sum;
		logic root_init;
		logic root_step;
		logic insert;
		logic next_slot;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic keep;
		logic last_slot;
		logic root_last;
		logic emit_last;
		logic out_free;
	} sts_t;

endpackage

// ===== design/radius_query_sorted_by_distance.sv =====
// load item: taken while idle, no result; next item can follow at once
// query item: captured, then per slot difference, two squares, sum, compare,
//   and in range also 16 square-root steps and an insert, then emits results
// one shared squarer and a one-step-per-cycle square-root unit set the rate
// reset clears the target table to zero and sets the radius to 72
module radius_query_sorted_by_distance
	import rqsd_pkg::*;
#(
	parameter int NUM_TARGETS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [RAD_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	rqsd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_op    (item.op),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	rqsd_dp #(
		.NUM_TARGETS (NUM_TARGETS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_data     (cfg_data),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

// ===== design/rqsd_ctrl.sv =====
// query sequencer: steps through slots, square root, insertion and result output
module rqsd_ctrl
	import rqsd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic item_op,
	output logic item_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIFF = 4'd1;
	localparam logic [3:0] S_MULX = 4'd2;
	localparam logic [3:0] S_MULY = 4'd3;
	localparam logic [3:0] S_SUM  = 4'd4;
	localparam logic [3:0] S_CMP  = 4'd5;
	localparam logic [3:0] S_ROOT = 4'd6;
	localparam logic [3:0] S_INS  = 4'd7;
	localparam logic [3:0] S_EMIT = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					if (item_op == OP_QUERY) begin
						cmd.start = 1'b1;
						state_d   = S_DIFF;
					end else begin
						cmd.load_we = 1'b1;
					end
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_MULX;
			end
			S_MULX: begin
				cmd.mulx = 1'b1;
				state_d  = S_MULY;
			end
			S_MULY: begin
				cmd.muly = 1'b1;
				state_d  = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.keep) begin
					cmd.root_init = 1'b1;
					state_d       = S_ROOT;
				end else if (sts.last_slot) begin
					state_d = S_EMIT;
				end else begin
					cmd.next_slot = 1'b1;
					state_d       = S_DIFF;
				end
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				if (sts.root_last) begin
					state_d = S_INS;
				end
			end
			S_INS: begin
				cmd.insert = 1'b1;
				if (sts.last_slot) begin
					state_d = S_EMIT;
				end else begin
					cmd.next_slot = 1'b1;
					state_d       = S_DIFF;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/rqsd_dp.sv =====
// datapath: target table, distance, square root, sorted list and result register
module rqsd_dp
	import rqsd_pkg::*;
#(
	parameter int NUM_TARGETS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  item_t            item,
	input  logic             cfg_we,
	input  logic [RAD_W-1:0] cfg_data,
	output result_t          result,
	output logic             result_valid,
	input  logic             result_stall
);

	localparam int IDX_W = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
	localparam int CNT_W = $clog2(NUM_TARGETS + 1);

	logic [RAD_W-1:0]         radius_q;
	logic signed [POS_W-1:0]  tx_q [NUM_TARGETS];
	logic signed [POS_W-1:0]  ty_q [NUM_TARGETS];

	logic signed [POS_W-1:0]  qx_q;
	logic signed [POS_W-1:0]  qy_q;
	logic [ID_W-1:0]          skip_q;
	logic [LIMIT_W-1:0]       limit_q;
	logic [IDX_W-1:0]         slot_q;

	logic signed [DIFF_W-1:0] dx_q;
	logic signed [DIFF_W-1:0] dy_q;
	logic [D2_W-1:0]          sqx_q;
	logic [D2_W-1:0]          sqy_q;
	logic [D2_W-1:0]          d2_q;

	logic [ROOT_W-1:0]        rem_q;
	logic [ROOT_W-1:0]        root_q;
	logic [STEP_W-1:0]        step_q;

	logic [KEY_W-1:0]         keys_q [NUM_TARGETS];
	logic [ID_W-1:0]          ids_q  [NUM_TARGETS];
	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         head_q;

	result_t                  res_q;
	logic                     res_valid_q;

	logic signed [D2_W-1:0]   mul_op;
	logic [D2_W-1:0]          mul_p;
	logic [ROOT_W-1:0]        root_bit;
	logic [ROOT_W-1:0]        root_try;
	logic [KEY_W-1:0]         key_new;
	logic [ID_W-1:0]          id_new;
	logic                     big      [NUM_TARGETS];
	logic                     big_prev [NUM_TARGETS];
	logic [KEY_W-1:0]         keys_d   [NUM_TARGETS];
	logic [ID_W-1:0]          ids_d    [NUM_TARGETS];
	logic                     load_ok;

	// one squarer shared by both axes
	assign mul_op = cmd.mulx ? D2_W'(dx_q) : D2_W'(dy_q);
	assign mul_p  = $unsigned(mul_op * mul_op);

	assign root_bit = ROOT_W'(1) << {step_q, 1'b0};
	assign root_try = root_q + root_bit;

	assign key_new = root_q[KEY_W-1:0];
	assign id_new  = ID_W'(slot_q);
	assign load_ok = ({1'b0, item.target_slot} < (ID_W + 1)'(NUM_TARGETS));

	assign sts.keep      = (d2_q < D2_W'(limit_q)) && (ID_W'(slot_q) != skip_q);
	assign sts.last_slot = (slot_q == IDX_W'(NUM_TARGETS - 1));
	assign sts.root_last = (step_q == '0);
	assign sts.emit_last = (count_q == '0) || ((CNT_W'(head_q) + CNT_W'(1)) == count_q);
	assign sts.out_free  = !res_valid_q || !result_stall;

	assign result       = res_q;
	assign result_valid = res_valid_q;

	// stable insertion: new entry goes after every stored key not above it
	always_comb begin
		for (int j = 0; j < NUM_TARGETS; j++) begin
			big[j] = (CNT_W'(j) >= count_q) || (keys_q[j] > key_new);
		end
		big_prev[0] = 1'b0;
		for (int j = 1; j < NUM_TARGETS; j++) begin
			big_prev[j] = big[j-1];
		end
		for (int j = 0; j < NUM_TARGETS; j++) begin
			if (!big[j]) begin
				keys_d[j] = keys_q[j];
				ids_d[j]  = ids_q[j];
			end else if (!big_prev[j]) begin
				keys_d[j] = key_new;
				ids_d[j]  = id_new;
			end else begin
				keys_d[j] = keys_q[(j > 0) ? j - 1 : 0];
				ids_d[j]  = ids_q[(j > 0) ? j - 1 : 0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			for (int i = 0; i < NUM_TARGETS; i++) begin
				tx_q[i] <= '0;
				ty_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_data;
			end
			if (cmd.load_we && load_ok) begin
				tx_q[item.target_slot[IDX_W-1:0]] <= item.pos_x;
				ty_q[item.target_slot[IDX_W-1:0]] <= item.pos_y;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			count_q     <= '0;
			head_q      <= '0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				slot_q  <= '0;
				count_q <= '0;
				head_q  <= '0;
			end else if (cmd.next_slot) begin
				slot_q <= slot_q + IDX_W'(1);
			end
			if (cmd.insert) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.root_init) begin
				step_q <= ROOT_FIRST;
			end else if (cmd.root_step) begin
				step_q <= step_q - STEP_W'(1);
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
				if (count_q != '0) begin
					head_q <= head_q + IDX_W'(1);
				end
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qx_q    <= item.pos_x;
			qy_q    <= item.pos_y;
			skip_q  <= item.skip_target;
			limit_q <= LIMIT_W'(radius_q) * LIMIT_W'(radius_q);
		end
		if (cmd.diff) begin
			dx_q <= DIFF_W'(tx_q[slot_q]) - DIFF_W'(qx_q);
			dy_q <= DIFF_W'(ty_q[slot_q]) - DIFF_W'(qy_q);
		end
		if (cmd.mulx) begin
			sqx_q <= mul_p;
		end
		if (cmd.muly) begin
			sqy_q <= mul_p;
		end
		if (cmd.sum) begin
			d2_q <= sqx_q + sqy_q;
		end
		// kept distances lie below the limit, so they fit the root width
		if (cmd.root_init) begin
			rem_q  <= ROOT_W'(d2_q[LIMIT_W-1:0]);
			root_q <= '0;
		end else if (cmd.root_step) begin
			if (rem_q >= root_try) begin
				rem_q  <= rem_q - root_try;
				root_q <= (root_q >> 1) + root_bit;
			end else begin
				root_q <= root_q >> 1;
			end
		end
		if (cmd.insert) begin
			for (int j = 0; j < NUM_TARGETS; j++) begin
				keys_q[j] <= keys_d[j];
				ids_q[j]  <= ids_d[j];
			end
		end
		if (cmd.emit) begin
			if (count_q == '0) begin
				res_q.target_id <= '0;
				res_q.found     <= 1'b0;
				res_q.last      <= 1'b1;
			end else begin
				res_q.target_id <= ids_q[head_q];
				res_q.found     <= 1'b1;
				res_q.last      <= sts.emit_last;
			end
		end
	end

endmodule

// ===== sim/radius_query_sorted_by_distance_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the sorted radius query block
module radius_query_sorted_by_distance_test
	import rqsd_pkg::*;
();

	localparam int NUM_TARGETS = 4;
	localparam int TAIL_CYCLES = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int NUM_PHASES  = 7;

	typedef enum int {FLOW, CHOPPY, CLOGGED} stall_mode_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	item_t            item = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	result_t          result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [RAD_W-1:0] cfg_data = '0;

	radius_query_sorted_by_distance #(
		.NUM_TARGETS(NUM_TARGETS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// own copy of the target table and radius
	logic signed [POS_W-1:0] slot_x [NUM_TARGETS];
	logic signed [POS_W-1:0] slot_y [NUM_TARGETS];
	logic [RAD_W-1:0]        radius_now;

	result_t nearest_q [$];
	item_t   pending_items [$];
	int      errors = 0;
	logic    item_taken = 1'b0;

	int          burst_left = 0;
	int          gap_left = 0;
	bit          steady_sender = 1'b0;
	int          hold_left = 0;
	int          holds_asked = 0;
	int          holds_served = 0;
	stall_mode_t stall_mode = FLOW;
	int          mode_left = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("radius_query_sorted_by_distance_test: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	// updates the table on a load, queues the ordered neighbour list on a query
	task automatic predict_neighbours(input item_t it);
		longint  dx, dy, d2, lim, key, trial;
		longint  keys [NUM_TARGETS];
		int      ids [NUM_TARGETS];
		int      n, j;
		result_t r;
		n = 0;
		if (it.op == OP_LOAD) begin
			if (it.target_slot < NUM_TARGETS) begin
				slot_x[it.target_slot] = it.pos_x;
				slot_y[it.target_slot] = it.pos_y;
			end
		end else begin
			lim = longint'(radius_now) * longint'(radius_now);
			for (int i = 0; i < NUM_TARGETS; i++) begin
				dx = longint'(slot_x[i]) - longint'($signed(it.pos_x));
				dy = longint'(slot_y[i]) - longint'($signed(it.pos_y));
				d2 = dx * dx + dy * dy;
				if (i != it.skip_target && d2 < lim) begin
					// integer square root, one bit at a time
					key = 0;
					for (int b = 15; b >= 0; b--) begin
						trial = key | (longint'(1) << b);
						if (trial * trial <= d2)
							key = trial;
					end
					// equal keys stay in slot order
					j = n;
					while (j > 0 && keys[j - 1] > key) begin
						keys[j] = keys[j - 1];
						ids[j]  = ids[j - 1];
						j--;
					end
					keys[j] = key;
					ids[j]  = i;
					n++;
				end
			end
			if (n == 0) begin
				r.target_id = '0;
				r.found     = 1'b0;
				r.last      = 1'b1;
				nearest_q = {nearest_q, r};
			end else begin
				for (int k = 0; k < n; k++) begin
					r.target_id = ID_W'(ids[k]);
					r.found     = 1'b1;
					r.last      = (k == n - 1);
					nearest_q = {nearest_q, r};
				end
			end
		end
	endtask

	// sampling at the rising edge: accepted items feed the predictor
	always @(posedge clk) begin : watch
		result_t want;
		if (!arst_n) begin
			item_taken <= 1'b0;
		end else begin
			item_taken <= item_valid && !item_stall;
			if (item_valid && !item_stall)
				predict_neighbours(item);
			if (result_valid && !result_stall) begin
				if (nearest_q.size() == 0) begin
					report_mismatch("result with nothing awaited", int'(result.target_id), 0);
				end else begin
					want = nearest_q.pop_front();
					if (result.target_id !== want.target_id)
						report_mismatch("target_id", int'(result.target_id),
							int'(want.target_id));
					if (result.found !== want.found)
						report_mismatch("found", int'(result.found), int'(want.found));
					if (result.last !== want.last)
						report_mismatch("last", int'(result.last), int'(want.last));
				end
			end
		end
	end

	// sender: bursts of items with random gaps between bursts, or none when steady
	always @(negedge clk) begin : drive
		if (arst_n && (!item_valid || item_taken)) begin
			if (gap_left > 0) begin
				item_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_items.size() > 0) begin
				item <= pending_items.pop_front();
				item_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= steady_sender ? 0 : $urandom_range(1, 10);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern of its own, plus a long hold when asked
	always @(negedge clk) begin : receive
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 2));
				mode_left <= $urandom_range(10, 150);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				FLOW:    result_stall <= 1'b0;
				CHOPPY:  result_stall <= 1'($urandom_range(0, 1));
				default: result_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	function automatic void queue_item(logic op, int slot, int x, int y, int skip);
		item_t it;
		it.op          = op;
		it.target_slot = ID_W'(slot);
		it.pos_x       = POS_W'(x);
		it.pos_y       = POS_W'(y);
		it.skip_target = ID_W'(skip);
		pending_items = {pending_items, it};
	endfunction

	function automatic int clamp16(int v);
		return (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
	endfunction

	// mostly clustered around a centre so that queries see neighbours
	function automatic item_t make_random_item(int cx, int cy, int spread);
		item_t it;
		it.op = ($urandom_range(0, 99) < 55) ? OP_QUERY : OP_LOAD;
		it.target_slot = ($urandom_range(0, 9) < 8) ?
			ID_W'($urandom_range(0, NUM_TARGETS - 1)) : ID_W'($urandom_range(0, 15));
		it.skip_target = ($urandom_range(0, 9) < 7) ?
			ID_W'($urandom_range(0, NUM_TARGETS - 1)) : ID_W'($urandom_range(0, 15));
		if ($urandom_range(0, 9) < 2) begin
			it.pos_x = POS_W'($urandom);
			it.pos_y = POS_W'($urandom);
		end else begin
			it.pos_x = POS_W'(clamp16(cx + int'($urandom_range(0, 2 * spread)) - spread));
			it.pos_y = POS_W'(clamp16(cy + int'($urandom_range(0, 2 * spread)) - spread));
		end
		return it;
	endfunction

	function automatic int random_centre();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 40))
				: -32768 + int'($urandom_range(0, 40));
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// stimulus waits until every awaited result is in and the block has settled
	task automatic drain();
		while (pending_items.size() > 0 || item_valid || nearest_q.size() > 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_radius(input logic [RAD_W-1:0] r);
		@(negedge clk);
		cfg_data <= r;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		radius_now = r;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [RAD_W-1:0] phase_radius [NUM_PHASES];
		item_t            it;
		int               cx, cy, spread, goal, kept;

		for (int i = 0; i < NUM_TARGETS; i++) begin
			slot_x[i] = '0;
			slot_y[i] = '0;
		end
		radius_now = RADIUS_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: every slot at distance zero, then nothing in range
		queue_item(OP_QUERY, 0, 0, 0, 15);
		queue_item(OP_QUERY, 3, 100, 0, 0);
		// keys tie between slots 0, 1 and 3 although slot 0's squared distance differs from theirs
		queue_item(OP_LOAD, 0, 2, 1, 0);
		queue_item(OP_LOAD, 1, 2, 0, 0);
		queue_item(OP_LOAD, 2, 1, 0, 0);
		queue_item(OP_LOAD, 3, 0, 2, 0);
		// loads beyond the table are dropped
		queue_item(OP_LOAD, 9, 5, 5, 0);
		queue_item(OP_LOAD, 15, -32768, 32767, 0);
		queue_item(OP_QUERY, 0, 0, 0, 4);
		queue_item(OP_QUERY, 0, 0, 0, 2);
		queue_item(OP_QUERY, 0, 0, 0, 15);
		// just inside and just outside the radius
		queue_item(OP_QUERY, 0, 71, 0, 8);
		queue_item(OP_QUERY, 0, 72, 0, 15);
		queue_item(OP_LOAD, 1, -32768, -32768, 0);
		queue_item(OP_LOAD, 2, 32767, 32767, 0);
		queue_item(OP_LOAD, 3, 32767, -32768, 0);
		queue_item(OP_QUERY, 0, -32768, -32768, 15);
		queue_item(OP_QUERY, 0, 32767, 32767, 2);
		drain();
		write_radius('0);
		@(posedge clk);
		queue_item(OP_QUERY, 0, 2, 1, 15);
		drain();
		write_radius('1);
		@(posedge clk);
		queue_item(OP_QUERY, 0, 0, 0, 15);
		queue_item(OP_QUERY, 0, 0, -32768, 15);
		queue_item(OP_QUERY, 0, 1, -32768, 15);
		queue_item(OP_QUERY, 0, -32768, 32767, 0);
		drain();

		phase_radius[0] = '1;
		phase_radius[1] = RAD_W'($urandom_range(8, 300));
		phase_radius[2] = RAD_W'(1);
		phase_radius[3] = '0;
		phase_radius[4] = RAD_W'(5);
		phase_radius[5] = RAD_W'($urandom_range(1000, 32767));
		phase_radius[6] = RADIUS_RESET;

		foreach (phase_radius[p]) begin
			write_radius(phase_radius[p]);
			@(posedge clk);
			steady_sender = ($urandom_range(0, 2) == 0);
			// widest radius here: results back up behind a long receiver hold
			if (p == 0) begin
				holds_asked++;
				steady_sender = 1'b1;
			end
			cx = random_centre();
			cy = random_centre();
			spread = (phase_radius[p] < 4) ? 4 : int'(phase_radius[p]) + phase_radius[p] / 4;
			if (spread > 32767)
				spread = 32767;
			goal = $urandom_range(50, 64);
			kept = 0;
			while (kept < goal) begin
				it = make_random_item(cx, cy, spread);
				pending_items = {pending_items, it};
				if (it.op == OP_QUERY || it.target_slot < NUM_TARGETS)
					kept++;
			end
			drain();
		end

		if (errors == 0)
			$display("radius_query_sorted_by_distance_test: PASS");
		else
			$display("radius_query_sorted_by_distance_test: FAIL");
		$finish;
	end

endmodule
